// ----- rtl/rcf_pkg.sv -----
// ----------------------------------------------------------------------------
// rcf_pkg : shared types and constants of the RGB 3x3 convolution filter
// Pixel, window column and result types, kernel selector and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rcf_pkg;

    // window is WIN_SIZE x WIN_SIZE pixels
    localparam int WIN_SIZE = 3;

    // signed width of one column partial sum (edge kernel peaks at +/-2040)
    localparam int SUM_W = 12;

    // stream widths
    localparam int PIX_W      = 24;
    localparam int OUT_DATA_W = 56;

    // kernel selector
    typedef enum logic [1:0] {
        MODE_BOX     = 2'd0,
        MODE_SHARPEN = 2'd1,
        MODE_EDGE    = 2'd2,
        MODE_GAUSS   = 2'd3
    } mode_t;

    // configuration register indexes
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_FILTER_MODE  = 2'd0;
    localparam cfg_idx_t CFG_FRAME_WIDTH  = 2'd1;
    localparam cfg_idx_t CFG_FRAME_HEIGHT = 2'd2;

    // one pixel, red in the low byte
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    // one window column, three rows
    typedef struct packed {
        rgb_t row_low;
        rgb_t row_mid;
        rgb_t row_up;
    } column_t;

    // weighted sum of one column, per channel
    typedef struct packed {
        logic signed [SUM_W-1:0] blue;
        logic signed [SUM_W-1:0] green;
        logic signed [SUM_W-1:0] red;
    } col_sum_t;

    // control shared by all window cells
    typedef struct packed {
        logic  shift;
        logic  capture;
        mode_t mode;
    } cell_ctrl_t;

    // position data that travels with a result
    typedef struct packed {
        logic        last;
        logic [10:0] col;
        logic [15:0] row;
    } meta_t;

    // one result beat
    typedef struct packed {
        logic        last;
        logic [10:0] col;
        logic [15:0] row;
        rgb_t        pix;
    } res_t;

endpackage : rcf_pkg

`default_nettype wire

// ----- rtl/rcf_line_buf.sv -----
// ----------------------------------------------------------------------------
// rcf_line_buf : one line of pixels
// Simple dual-port memory, registered read, read-first on address collision.
// ----------------------------------------------------------------------------
`default_nettype none

module rcf_line_buf #(
    parameter  int DEPTH = 2048,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic           clk,
    input  wire logic           rd_en,
    input  wire logic [AW-1:0]  rd_addr,
    output rcf_pkg::rgb_t       rd_data,
    input  wire logic           wr_en,
    input  wire logic [AW-1:0]  wr_addr,
    input  wire rcf_pkg::rgb_t  wr_data
);

    rcf_pkg::rgb_t mem [DEPTH];
    rcf_pkg::rgb_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule : rcf_line_buf

`default_nettype wire

// ----- rtl/rcf_win_cell.sv -----
// ----------------------------------------------------------------------------
// rcf_win_cell : one column of the 3x3 window
// Holds three pixels, passes them to its neighbour on shift, and registers
// the kernel-weighted sum of its column for each channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rcf_win_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rcf_pkg::cell_ctrl_t ctrl,
    input  wire logic                centre,   // middle column of the window
    input  wire rcf_pkg::column_t    col_in,
    output rcf_pkg::column_t         col_out,
    output rcf_pkg::col_sum_t        sum_out
);

    localparam int SW = rcf_pkg::SUM_W;

    rcf_pkg::column_t  col_reg;
    rcf_pkg::col_sum_t sum_reg;
    rcf_pkg::col_sum_t sum_next;

    // floor(p/9) as p*57 >> 9, exact over 0..255
    function automatic logic [4:0] div9(input logic [7:0] p);
        logic [13:0] prod;
        prod = 14'(p) * 14'd57;
        return prod[13:9];
    endfunction

    // a: upper row, b: middle row, c: lower row
    function automatic logic signed [SW-1:0] col_term(
        input rcf_pkg::mode_t m,
        input logic           ctr,
        input logic [7:0]     a,
        input logic [7:0]     b,
        input logic [7:0]     c
    );
        logic signed [SW-1:0] sa;
        logic signed [SW-1:0] sb;
        logic signed [SW-1:0] sc;
        logic signed [SW-1:0] res;
        sa = $signed(SW'(a));
        sb = $signed(SW'(b));
        sc = $signed(SW'(c));
        unique case (m)
            rcf_pkg::MODE_BOX:
                res = $signed(SW'(div9(a))) + $signed(SW'(div9(b)))
                    + $signed(SW'(div9(c)));
            rcf_pkg::MODE_SHARPEN:
                res = ctr ? ((sb <<< 2) + sb - sa - sc) : -sb;
            rcf_pkg::MODE_EDGE:
                res = ctr ? ((sb <<< 3) - sa - sc) : -(sa + sb + sc);
            rcf_pkg::MODE_GAUSS:
                res = ctr ? ((sa >>> 3) + (sb >>> 2) + (sc >>> 3))
                          : ((sa >>> 4) + (sb >>> 3) + (sc >>> 4));
        endcase
        return res;
    endfunction

    always_comb
    begin
        sum_next.red   = col_term(ctrl.mode, centre, col_reg.row_up.red,
                                  col_reg.row_mid.red, col_reg.row_low.red);
        sum_next.green = col_term(ctrl.mode, centre, col_reg.row_up.green,
                                  col_reg.row_mid.green, col_reg.row_low.green);
        sum_next.blue  = col_term(ctrl.mode, centre, col_reg.row_up.blue,
                                  col_reg.row_mid.blue, col_reg.row_low.blue);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            if (ctrl.shift)
            begin
                col_reg <= col_in;
            end
            if (ctrl.capture)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    assign col_out = col_reg;
    assign sum_out = sum_reg;

endmodule : rcf_win_cell

`default_nettype wire

// ----- rtl/rgb_conv3x3_filter.sv -----
// ----------------------------------------------------------------------------
// rgb_conv3x3_filter : streaming 3x3 convolution on RGB pixels
// Line stores, a row of window cells and a saturating output stage.
// ----------------------------------------------------------------------------
// Feed RGB pixels in raster order on the slave stream, one beat per pixel;
// the block takes one pixel per clock for as long as results are drained,
// and a result passes the line-store read, window, column-sum and output
// registers. Only interior pixels produce a result beat, tagged with the row
// and column of the interior pixel; tlast marks the last one of the frame.
// The kernel (box blur, sharpen, edge, Gaussian) is applied per channel with
// integer arithmetic, saturated to 0..255. The pipeline stalls as a whole
// and only when a result is held in the skid register, so tready is a flop.
// Configuration is written through the cfg channel while the stream is
// idle; a write of frame width or height restarts the frame at row 0,
// column 0. Line stores are not cleared: the first two rows of a frame
// only fill them.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_conv3x3_filter #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // pixel stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // pix_red, pix_green, pix_blue

    // result stream out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // out_red, out_green, out_blue,
                                             // out_row, out_col, zero pad
    output logic             m_axis_tlast,   // frame_last

    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);        // column counter / address
    localparam int EW   = $clog2(MAX_WIDTH + 1);    // effective width
    localparam int CXW  = (CW > 11) ? CW : 11;      // column minus one
    localparam int SW   = rcf_pkg::SUM_W;
    localparam int TW   = SW + 2;                   // three column sums
    localparam int NWIN = rcf_pkg::WIN_SIZE;
    localparam int CTR  = 1;                        // centre cell
    localparam int PADW = rcf_pkg::OUT_DATA_W - $bits(rcf_pkg::res_t) + 1;

    // ---------------------------------------------------------------- helpers
    function automatic logic [EW-1:0] eff_width(input logic [11:0] fw);
        logic [EW-1:0] w;
        if (fw < 12'd3)
        begin
            w = EW'(3);
        end
        else if (32'(fw) > MAX_WIDTH)
        begin
            w = EW'(MAX_WIDTH);
        end
        else
        begin
            w = EW'(fw);
        end
        return w;
    endfunction

    function automatic logic [15:0] eff_height(input logic [15:0] fh);
        return (fh < 16'd3) ? 16'd3 : fh;
    endfunction

    function automatic logic signed [TW-1:0] add3(
        input logic signed [SW-1:0] a,
        input logic signed [SW-1:0] b,
        input logic signed [SW-1:0] c
    );
        return TW'(a) + TW'(b) + TW'(c);
    endfunction

    function automatic logic [7:0] sat8(input logic signed [TW-1:0] v);
        logic [7:0] r;
        priority if (v < $signed(TW'(0)))
        begin
            r = 8'd0;
        end
        else if (v > $signed(TW'(255)))
        begin
            r = 8'd255;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------- config regs
    logic            cfg_wr;
    logic            geom_wr;
    rcf_pkg::mode_t  mode_reg;
    logic [EW-1:0]   width_eff_reg;
    logic [15:0]     height_eff_reg;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign geom_wr   = cfg_wr && ((cfg_index == rcf_pkg::CFG_FRAME_WIDTH) ||
                                  (cfg_index == rcf_pkg::CFG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= rcf_pkg::MODE_BOX;
            width_eff_reg  <= eff_width(12'd640);
            height_eff_reg <= eff_height(16'd480);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                rcf_pkg::CFG_FILTER_MODE:
                    mode_reg <= rcf_pkg::mode_t'(cfg_data[1:0]);
                rcf_pkg::CFG_FRAME_WIDTH:
                    width_eff_reg <= eff_width(cfg_data[11:0]);
                rcf_pkg::CFG_FRAME_HEIGHT:
                    height_eff_reg <= eff_height(cfg_data);
                default:
                    ;   // unknown index: ignored
            endcase
        end
    end

    // ------------------------------------------------------ stage 0: accept
    logic              en;          // whole pipeline advances
    logic              accept;
    logic              skid_valid_reg;
    rcf_pkg::rgb_t     cur_pix;

    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    logic [15:0]       row_reg;
    logic [15:0]       row_next;
    logic [EW-1:0]     col_inc;
    logic [16:0]       row_inc;
    logic              col_wrap;
    logic              row_wrap;
    logic              emit0;
    logic [CXW-1:0]    col_m1;
    rcf_pkg::meta_t    meta0;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;
    assign cur_pix       = rcf_pkg::rgb_t'(s_axis_tdata);

    always_comb
    begin
        col_inc  = EW'(col_reg) + EW'(1);
        row_inc  = 17'(row_reg) + 17'd1;
        col_wrap = (col_inc >= width_eff_reg);
        row_wrap = (row_inc >= 17'(height_eff_reg));
        emit0    = (row_reg >= 16'd2) && (col_reg >= CW'(2));
        col_m1   = CXW'(col_reg) - CXW'(1);

        meta0.last = row_wrap && col_wrap;
        meta0.col  = col_m1[10:0];
        meta0.row  = row_reg - 16'd1;

        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? 16'd0 : row_inc[15:0];
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = row_reg;
        end
    end

    // raster position; a geometry write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (geom_wr)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------- line stores
    // middle line is written as the pixel enters; the upper line takes the
    // old middle value from the registered read data of the middle line
    rcf_pkg::rgb_t     mid_rd;
    rcf_pkg::rgb_t     up_rd;
    logic              v1_reg;
    logic              e1_reg;
    logic [CW-1:0]     addr1_reg;
    rcf_pkg::rgb_t     cur1_reg;
    rcf_pkg::meta_t    meta1_reg;

    rcf_line_buf #(
        .DEPTH   (MAX_WIDTH)
    ) u_line_mid (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (mid_rd),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (cur_pix)
    );

    rcf_line_buf #(
        .DEPTH   (MAX_WIDTH)
    ) u_line_up (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (up_rd),
        .wr_en   (en && v1_reg),
        .wr_addr (addr1_reg),
        .wr_data (mid_rd)
    );

    // -------------------------------------------------------- window cells
    // cell 2 takes the newest column, cell 0 holds the oldest
    rcf_pkg::cell_ctrl_t cell_ctrl;
    rcf_pkg::column_t    new_col;
    rcf_pkg::column_t    chain_in  [NWIN];
    rcf_pkg::column_t    win_col   [NWIN];
    rcf_pkg::col_sum_t   col_sum   [NWIN];

    assign cell_ctrl.shift   = en && v1_reg;
    assign cell_ctrl.capture = en;
    assign cell_ctrl.mode    = mode_reg;

    assign new_col.row_up  = up_rd;
    assign new_col.row_mid = mid_rd;
    assign new_col.row_low = cur1_reg;

    for (genvar g = 0; g < NWIN; g++)
    begin : g_cell
        if (g == NWIN - 1)
        begin : g_head
            assign chain_in[g] = new_col;
        end
        else
        begin : g_link
            assign chain_in[g] = win_col[g + 1];
        end

        rcf_win_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .centre  (g == CTR),
            .col_in  (chain_in[g]),
            .col_out (win_col[g]),
            .sum_out (col_sum[g])
        );
    end

    // ------------------------------------------------------ pipeline tags
    logic            r2_reg;
    logic            r3_reg;
    rcf_pkg::meta_t  meta2_reg;
    rcf_pkg::meta_t  meta3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            e1_reg <= 1'b0;
            r2_reg <= 1'b0;
            r3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= accept;
            e1_reg <= accept && emit0;
            r2_reg <= e1_reg;       // window now centred on the result pixel
            r3_reg <= r2_reg;       // column sums registered
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr1_reg <= col_reg;
            cur1_reg  <= cur_pix;
            meta1_reg <= meta0;
        end
        if (en)
        begin
            meta2_reg <= meta1_reg;
            meta3_reg <= meta2_reg;
        end
    end

    // ------------------------------------------------- final sum and clamp
    rcf_pkg::res_t p_data;

    always_comb
    begin
        p_data.last      = meta3_reg.last;
        p_data.col       = meta3_reg.col;
        p_data.row       = meta3_reg.row;
        p_data.pix.red   = sat8(add3(col_sum[0].red,   col_sum[1].red,
                                     col_sum[2].red));
        p_data.pix.green = sat8(add3(col_sum[0].green, col_sum[1].green,
                                     col_sum[2].green));
        p_data.pix.blue  = sat8(add3(col_sum[0].blue,  col_sum[1].blue,
                                     col_sum[2].blue));
    end

    // ------------------------------------------------ output and skid regs
    logic          out_valid_reg;
    logic          out_valid_next;
    rcf_pkg::res_t out_data_reg;
    rcf_pkg::res_t out_data_next;
    logic          skid_valid_next;
    rcf_pkg::res_t skid_data_reg;
    rcf_pkg::res_t skid_data_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (en)
        begin
            if (r3_reg && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_next = 1'b1;
                out_data_next  = p_data;
            end
            else if (r3_reg)
            begin
                // output beat still waiting: park the new one
                skid_valid_next = 1'b1;
                skid_data_next  = p_data;
            end
            else if (m_axis_tready)
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (m_axis_tready)
        begin
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_data_reg.last;
    assign m_axis_tdata  = {PADW'(0), out_data_reg.col, out_data_reg.row,
                            out_data_reg.pix};

    // ------------------------------------------------------------ checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held with empty output register");

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(col_reg) < width_eff_reg)
        else $error("column counter beyond frame width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < height_eff_reg)
        else $error("row counter beyond frame height");

    a_no_border_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.row != 16'd0))
        else $error("result beat on top border row");

endmodule : rgb_conv3x3_filter

`default_nettype wire
